[rtl/usan_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usan_pkg: shared types and constants of the UTF-8 stream sanitiser
// Beat payloads, the job word passed from front to back, and lead decoding.
// ----------------------------------------------------------------------------
package usan_pkg;

  localparam int unsigned JobBytes = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic OpData   = 1'b0;
  localparam logic OpFinish = 1'b1;

  localparam logic [7:0] RepByte0 = 8'hEF;
  localparam logic [7:0] RepByte1 = 8'hBF;
  localparam logic [7:0] RepByte2 = 8'hBD;

  localparam logic [7:0] ContLo = 8'h80;
  localparam logic [7:0] ContHi = 8'hBF;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One job: the bytes that a single input beat releases, in stream order.
  typedef struct packed {
    logic [2:0]                cnt;
    logic [JobBytes-1:0][7:0]  data;
  } job_t;

  typedef struct packed {
    logic [2:0] len;
    logic [7:0] lo;
    logic [7:0] hi;
  } lead_info_t;

  // Sequence length of a lead byte (zero when it is no valid lead) and the
  // allowed range of its first continuation byte.
  function automatic lead_info_t lead_decode(logic [7:0] c);
    lead_info_t r;
    r.len = 3'd0;
    r.lo  = ContLo;
    r.hi  = ContHi;
    if (c inside {[8'hC2:8'hDF]}) begin
      r.len = 3'd2;
    end else if (c == 8'hE0) begin
      r.len = 3'd3;
      r.lo  = 8'hA0;
    end else if (c inside {[8'hE1:8'hEC], [8'hEE:8'hEF]}) begin
      r.len = 3'd3;
    end else if (c == 8'hED) begin
      r.len = 3'd3;
      r.hi  = 8'h9F;
    end else if (c == 8'hF0) begin
      r.len = 3'd4;
      r.lo  = 8'h90;
    end else if (c inside {[8'hF1:8'hF3]}) begin
      r.len = 3'd4;
    end else if (c == 8'hF4) begin
      r.len = 3'd4;
      r.hi  = 8'h8F;
    end
    return r;
  endfunction

endpackage

[rtl/utf8_stream_sanitizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer: streaming UTF-8 validator and sanitiser
// Forwards well-formed UTF-8 and replaces ill-formed parts with U+FFFD.
// ----------------------------------------------------------------------------
// Usage: input beats carry one byte or a finish marker on a valid/ready
// channel; output beats carry one sanitised byte each, with last set on the
// final byte that an input beat releases. A beat that only extends a held
// partial sequence, or a finish with nothing held, releases no output beat.
// The front classifies each accepted beat in the cycle it is accepted and
// pushes a job of one to six bytes into a two-entry queue. The back loads a
// job from the queue into its job register and sends one byte per cycle while
// the receiver is ready, so a byte of an accepted beat passes the queue
// register and then the back's job register before it reaches the output.
// Throughput is one input beat per cycle while each beat releases at most one
// byte and the receiver is ready; a longer job holds the back until all its
// bytes are sent; the queue fills and lowers in_ready_o until the back is done.
// After reset nothing is held and both queue and back are empty. When the
// receiver stalls, the current byte holds steady on the output, the queue
// fills, and then the input stalls; no byte is lost.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer import usan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Front to queue.
  logic f_valid, f_ready;
  job_t f_job;
  // Queue to back.
  logic b_valid, b_ready;
  job_t b_job;

  usan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  usan_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_job_i   (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_job_o    (b_job)
  );

  usan_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/usan_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usan_front: accepts input beats and classifies them into output jobs
// Keeps the held partial sequence and emits one job per producing beat.
// ----------------------------------------------------------------------------
module usan_front import usan_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      exp_len_q, exp_len_d;

  logic       accept;
  logic [7:0] b;
  lead_info_t held_info, new_info;
  logic       is_cont;
  job_t       job;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_item_i.in_byte;
  assign held_info  = lead_decode(held_q[0]);
  assign new_info   = lead_decode(b);
  assign is_cont    = (b[7:6] == 2'b10);

  always_comb begin
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    job.cnt    = 3'd0;
    job.data   = '0;
    if (in_item_i.op == OpFinish) begin
      if (held_cnt_q != 2'd0) begin
        job.cnt     = 3'd3;
        job.data[0] = RepByte0;
        job.data[1] = RepByte1;
        job.data[2] = RepByte2;
        held_cnt_d  = 2'd0;
        exp_len_d   = 3'd0;
      end
    end else if (held_cnt_q == 2'd0) begin
      if (!b[7]) begin
        job.cnt     = 3'd1;
        job.data[0] = b;
      end else if (new_info.len == 3'd0) begin
        job.cnt     = 3'd3;
        job.data[0] = RepByte0;
        job.data[1] = RepByte1;
        job.data[2] = RepByte2;
      end else begin
        held_d[0]  = b;
        held_cnt_d = 2'd1;
        exp_len_d  = new_info.len;
      end
    end else if (is_cont) begin
      if (held_cnt_q == 2'd1 && (b < held_info.lo || b > held_info.hi)) begin
        job.cnt     = 3'd6;
        job.data[0] = RepByte0;
        job.data[1] = RepByte1;
        job.data[2] = RepByte2;
        job.data[3] = RepByte0;
        job.data[4] = RepByte1;
        job.data[5] = RepByte2;
        held_cnt_d  = 2'd0;
        exp_len_d   = 3'd0;
      end else if (({1'b0, held_cnt_q} + 3'd1) >= exp_len_q || held_cnt_q == 2'd3) begin
        job.cnt     = {1'b0, held_cnt_q} + 3'd1;
        job.data[0] = held_q[0];
        job.data[1] = (held_cnt_q > 2'd1) ? held_q[1] : b;
        job.data[2] = (held_cnt_q > 2'd2) ? held_q[2] : b;
        job.data[3] = b;
        held_cnt_d  = 2'd0;
        exp_len_d   = 3'd0;
      end else begin
        case (held_cnt_q)
          2'd1:    held_d[1] = b;
          default: held_d[2] = b;
        endcase
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end else begin
      // The held sequence is broken: replace it, then take the byte afresh.
      job.data[0] = RepByte0;
      job.data[1] = RepByte1;
      job.data[2] = RepByte2;
      held_cnt_d  = 2'd0;
      exp_len_d   = 3'd0;
      if (!b[7]) begin
        job.cnt     = 3'd4;
        job.data[3] = b;
      end else if (new_info.len == 3'd0) begin
        job.cnt     = 3'd6;
        job.data[3] = RepByte0;
        job.data[4] = RepByte1;
        job.data[5] = RepByte2;
      end else begin
        job.cnt    = 3'd3;
        held_d[0]  = b;
        held_cnt_d = 2'd1;
        exp_len_d  = new_info.len;
      end
    end
  end

  assign job_o       = job;
  assign job_valid_o = in_valid_i && (job.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

[rtl/usan_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usan_queue: short job queue between front and back
// Register FIFO; ready is taken from the fill level alone.
// ----------------------------------------------------------------------------
module usan_queue import usan_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[rtl/usan_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usan_back: serialises jobs into output beats
// Holds one job and sends its bytes one per beat, marking the last one.
// ----------------------------------------------------------------------------
module usan_back import usan_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  job_t       cur_q;
  logic       busy_q;
  logic [2:0] idx_q;
  logic       is_last;

  assign is_last             = (idx_q == (cur_q.cnt - 3'd1));
  assign job_ready_o         = !busy_q || (out_ready_i && is_last);
  assign out_valid_o         = busy_q;
  assign out_item_o.out_byte = cur_q.data[idx_q];
  assign out_item_o.last     = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (job_ready_o) begin
      busy_q <= job_valid_i;
      idx_q  <= 3'd0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      cur_q <= job_i;
    end
  end

endmodule
